### hdl/jpsm_pkg.sv
package jpsm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE      = 3'd0,
        CFG_INVERT_X       = 3'd1,
        CFG_INVERT_Y       = 3'd2,
        CFG_REPROBE_MS     = 3'd3,
        CFG_FAIL_LIMIT     = 3'd4,
        CFG_KIND1_BTN_HIGH = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] PORT_SEARCHING = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;

    localparam logic [6:0]  DEAD_ZONE_RST  = 7'd32;
    localparam logic [15:0] REPROBE_RST    = 16'd1000;
    localparam logic [7:0]  FAIL_LIMIT_RST = 8'd3;
    localparam logic [7:0]  FAIL_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic right;
        logic left;
        logic down;
        logic up;
        logic start;
    } t_stick_bits;

endpackage

### hdl/jpsm_in_if.sv
interface jpsm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  pin1_levels;
    logic [2:0]  pin2_levels;
    logic [31:0] now_ms;
    logic [5:0]  port_probe_kinds;
    logic        read_ok;
    logic [7:0]  stick_x_raw;
    logic [7:0]  stick_y_raw;
    logic [7:0]  stick_button_raw;

    modport source (
        output valid, pin1_levels, pin2_levels, now_ms, port_probe_kinds,
               read_ok, stick_x_raw, stick_y_raw, stick_button_raw,
        input  ready
    );
    modport sink (
        input  valid, pin1_levels, pin2_levels, now_ms, port_probe_kinds,
               read_ok, stick_x_raw, stick_y_raw, stick_button_raw,
        output ready
    );
endinterface

### hdl/jpsm_out_if.sv
interface jpsm_out_if;
    logic       valid;
    logic       ready;
    logic       a_pressed;
    logic       b_pressed;
    logic       start_pressed;
    logic       up_pressed;
    logic       down_pressed;
    logic       left_pressed;
    logic       right_pressed;
    logic [1:0] joystick_port;
    logic [1:0] joystick_kind;
    logic       joystick_lost;

    modport source (
        output valid, a_pressed, b_pressed, start_pressed, up_pressed, down_pressed,
               left_pressed, right_pressed, joystick_port, joystick_kind, joystick_lost,
        input  ready
    );
    modport sink (
        input  valid, a_pressed, b_pressed, start_pressed, up_pressed, down_pressed,
               left_pressed, right_pressed, joystick_port, joystick_kind, joystick_lost,
        output ready
    );
endinterface

### hdl/joystick_port_scan_pad_mapper.sv
// Channel   Dir  Modport        Payload
// i_in      in   sink           pin levels, time, probe kinds, stick read
// o_out     out  source         pad bits, bound port and kind, lost flag
// i_cfg_*   in   write port     register index and data, no read-back
//
// One transaction per cycle unless the result stalls. A transaction passes
// an input register, then the scan/probe/decode logic, then the result register.
// The state update happens as a transaction moves into the result register.
// A stalled result holds both registers; i_in.ready falls only when the
// input register is full and cannot advance. Synchronous active-low reset.
module joystick_port_scan_pad_mapper #(
    parameter int unsigned PORT_COUNT = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    jpsm_in_if.sink                         i_in,
    jpsm_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [jpsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jpsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import jpsm_pkg::*;

    localparam logic [1:0] PC = 2'(PORT_COUNT);

    logic [6:0]  r_dead_zone;
    logic        r_invert_x;
    logic        r_invert_y;
    logic [15:0] r_reprobe_ms;
    logic [7:0]  r_fail_limit;
    logic        r_kind1_btn_high;

    logic [1:0]  r_bound_port, n_bound_port;
    logic [1:0]  r_bound_kind, n_bound_kind;
    logic [7:0]  r_fail_count, n_fail_count;
    logic [1:0]  r_probe_index, n_probe_index;
    logic [31:0] r_last_probe, n_last_probe;
    t_stick_bits r_held, n_held;

    logic        r_in_vld;
    logic [2:0]  r_pin1;
    logic [2:0]  r_pin2;
    logic [31:0] r_now;
    logic [5:0]  r_kinds;
    logic        r_read_ok;
    logic [7:0]  r_x_raw;
    logic [7:0]  r_y_raw;
    logic [7:0]  r_btn_raw;

    logic        r_out_vld;
    logic        r_a, r_b, r_lost;
    t_stick_bits r_out_bits;
    logic [1:0]  r_out_port;
    logic [1:0]  r_out_kind;

    logic        adv;
    logic        n_a, n_b, n_lost;

    function automatic logic [1:0] axis_dir(
        input logic [7:0] v,
        input logic       inv,
        input logic [6:0] dz
    );
        logic signed [8:0] v9;
        logic signed [8:0] dz9;
        logic              pos;
        logic              neg;
        v9  = $signed({v[7], v});
        v9  = inv ? -v9 : v9;
        dz9 = $signed({2'b00, dz});
        pos = v9 > dz9;
        neg = !pos && (v9 < -dz9);
        return {pos, neg};
    endfunction

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone      <= DEAD_ZONE_RST;
            r_invert_x       <= 1'b0;
            r_invert_y       <= 1'b0;
            r_reprobe_ms     <= REPROBE_RST;
            r_fail_limit     <= FAIL_LIMIT_RST;
            r_kind1_btn_high <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEAD_ZONE:      r_dead_zone      <= i_cfg_data[6:0];
                CFG_INVERT_X:       r_invert_x       <= i_cfg_data[0];
                CFG_INVERT_Y:       r_invert_y       <= i_cfg_data[0];
                CFG_REPROBE_MS:     r_reprobe_ms     <= i_cfg_data[15:0];
                CFG_FAIL_LIMIT:     r_fail_limit     <= i_cfg_data[7:0];
                CFG_KIND1_BTN_HIGH: r_kind1_btn_high <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pin1    <= i_in.pin1_levels;
            r_pin2    <= i_in.pin2_levels;
            r_now     <= i_in.now_ms;
            r_kinds   <= i_in.port_probe_kinds;
            r_read_ok <= i_in.read_ok;
            r_x_raw   <= i_in.stick_x_raw;
            r_y_raw   <= i_in.stick_y_raw;
            r_btn_raw <= i_in.stick_button_raw;
        end
    end

    always_comb begin
        logic [1:0]  port;
        logic [1:0]  k;
        logic [31:0] elapsed;
        logic [7:0]  x8;
        logic [7:0]  y8;
        logic [1:0]  xd;
        logic [1:0]  yd;
        logic        pressed;
        logic [7:0]  fc_inc;

        n_a = 1'b0;
        n_b = 1'b0;
        for (int p = 0; p < PORT_COUNT && p < 3; p++) begin
            if (2'(p) != r_bound_port) begin
                if (!r_pin1[p]) n_a = 1'b1;
                if (!r_pin2[p]) n_b = 1'b1;
            end
        end

        n_bound_port  = r_bound_port;
        n_bound_kind  = r_bound_kind;
        n_fail_count  = r_fail_count;
        n_probe_index = r_probe_index;
        n_last_probe  = r_last_probe;
        n_held        = r_held;
        n_lost        = 1'b0;

        port = r_probe_index;
        if (port >= PC) port = port - PC;
        if (port >= PC) port = port - PC;
        if (port >= PC) port = port - PC;
        unique case (port)
            2'd0:    k = r_kinds[1:0];
            2'd1:    k = r_kinds[3:2];
            2'd2:    k = r_kinds[5:4];
            default: k = KIND_NONE;
        endcase
        elapsed = r_now - r_last_probe;

        if (r_bound_kind == KIND_SECOND) begin
            x8      = r_x_raw;
            y8      = r_y_raw;
            pressed = (r_btn_raw == 8'd0);
        end else begin
            x8      = r_x_raw ^ 8'h80;
            y8      = r_y_raw ^ 8'h80;
            pressed = r_kind1_btn_high ? (r_btn_raw != 8'd0) : (r_btn_raw == 8'd0);
        end
        xd = axis_dir(x8, r_invert_x, r_dead_zone);
        yd = axis_dir(y8, r_invert_y, r_dead_zone);

        fc_inc = (r_fail_count == FAIL_COUNT_MAX) ? FAIL_COUNT_MAX : r_fail_count + 8'd1;

        priority if (r_bound_port == PORT_SEARCHING) begin
            if (elapsed >= {16'd0, r_reprobe_ms}) begin
                n_last_probe  = r_now;
                n_probe_index = (port + 2'd1 == PC) ? 2'd0 : port + 2'd1;
                if (k == KIND_FIRST || k == KIND_SECOND) begin
                    n_bound_port = port;
                    n_bound_kind = k;
                    n_fail_count = 8'd0;
                end
            end
        end else if (r_read_ok) begin
            n_fail_count = 8'd0;
            n_held.start = pressed;
            n_held.right = xd[1];
            n_held.left  = xd[0];
            n_held.up    = yd[1];
            n_held.down  = yd[0];
        end else begin
            n_fail_count = fc_inc;
            if (fc_inc >= r_fail_limit) begin
                n_bound_port = PORT_SEARCHING;
                n_bound_kind = KIND_NONE;
                n_held       = '0;
                n_lost       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_port  <= PORT_SEARCHING;
            r_bound_kind  <= KIND_NONE;
            r_fail_count  <= 8'd0;
            r_probe_index <= 2'd0;
            r_last_probe  <= 32'd0;
            r_held        <= '0;
        end else if (adv) begin
            r_bound_port  <= n_bound_port;
            r_bound_kind  <= n_bound_kind;
            r_fail_count  <= n_fail_count;
            r_probe_index <= n_probe_index;
            r_last_probe  <= n_last_probe;
            r_held        <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a        <= n_a;
            r_b        <= n_b;
            r_out_bits <= n_held;
            r_out_port <= n_bound_port;
            r_out_kind <= n_bound_kind;
            r_lost     <= n_lost;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.a_pressed     = r_a;
    assign o_out.b_pressed     = r_b;
    assign o_out.start_pressed = r_out_bits.start;
    assign o_out.up_pressed    = r_out_bits.up;
    assign o_out.down_pressed  = r_out_bits.down;
    assign o_out.left_pressed  = r_out_bits.left;
    assign o_out.right_pressed = r_out_bits.right;
    assign o_out.joystick_port = r_out_port;
    assign o_out.joystick_kind = r_out_kind;
    assign o_out.joystick_lost = r_lost;

endmodule

### tb/testbench.sv
module testbench;
    import jpsm_pkg::*;

    localparam int NUM_PORTS    = 3;
    localparam int STICK_CENTER = 128;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic [2:0]  pin1;
        logic [2:0]  pin2;
        logic [31:0] now_ms;
        logic [5:0]  kinds;
        logic        read_ok;
        logic [7:0]  x_raw;
        logic [7:0]  y_raw;
        logic [7:0]  btn_raw;
    } t_poll_tick;

    typedef struct packed {
        logic        a;
        logic        b;
        t_stick_bits stick;
        logic [1:0]  port;
        logic [1:0]  kind;
        logic        lost;
    } t_pad_result;

    typedef struct packed {
        logic [6:0]  dead_zone;
        logic        invert_x;
        logic        invert_y;
        logic [15:0] reprobe_ms;
        logic [7:0]  fail_limit;
        logic        kind1_btn_high;
    } t_pad_cfg;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    jpsm_in_if  in_ch ();
    jpsm_out_if out_ch ();

    joystick_port_scan_pad_mapper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_pad_cfg    pad_cfg;
    logic [1:0]  pad_port      = PORT_SEARCHING;
    logic [1:0]  pad_kind      = KIND_NONE;
    logic [1:0]  probe_idx     = '0;
    logic [7:0]  fail_cnt      = '0;
    logic [31:0] last_probe_ms = '0;
    t_stick_bits held_bits     = '0;

    t_pad_result pad_result_q[$];
    int          err_count = 0;
    int          stall_cycles;
    bit          idle_on;
    logic [31:0] tick_ms;
    int          burst_left;

    always #10 i_clk = ~i_clk;

    function automatic int byte_signed(input logic [7:0] v);
        return v[7] ? int'(v) - 256 : int'(v);
    endfunction

    function automatic t_stick_bits stick_dirs(input int x, input int y);
        t_stick_bits d;
        int          dz;
        d  = '0;
        dz = int'(pad_cfg.dead_zone);
        if (pad_cfg.invert_x) x = -x;
        if (pad_cfg.invert_y) y = -y;
        if (x > dz) d.right = 1'b1;
        else if (x < -dz) d.left = 1'b1;
        if (y > dz) d.up = 1'b1;
        else if (y < -dz) d.down = 1'b1;
        return d;
    endfunction

    function automatic t_pad_result predict_tick(input t_poll_tick t);
        t_pad_result r;
        t_stick_bits d;
        logic [31:0] since;
        logic [1:0]  k;
        logic        pressed;
        int          port;
        int          p;
        r = '0;
        for (p = 0; p < NUM_PORTS; p++) begin
            if (p != int'(pad_port)) begin
                if (!t.pin1[p]) r.a = 1'b1;
                if (!t.pin2[p]) r.b = 1'b1;
            end
        end
        if (pad_port == PORT_SEARCHING) begin
            since = t.now_ms - last_probe_ms;
            if (since >= {16'd0, pad_cfg.reprobe_ms}) begin
                port          = int'(probe_idx) % NUM_PORTS;
                k             = t.kinds[2*port +: 2];
                last_probe_ms = t.now_ms;
                if (k == KIND_FIRST || k == KIND_SECOND) begin
                    pad_port = port[1:0];
                    pad_kind = k;
                    fail_cnt = '0;
                end
                port      = (port + 1) % NUM_PORTS;
                probe_idx = port[1:0];
            end
        end else if (t.read_ok) begin
            if (pad_kind == KIND_SECOND) begin
                d       = stick_dirs(byte_signed(t.x_raw), byte_signed(t.y_raw));
                pressed = (t.btn_raw == 8'd0);
            end else begin
                d       = stick_dirs(int'(t.x_raw) - STICK_CENTER,
                                     int'(t.y_raw) - STICK_CENTER);
                pressed = pad_cfg.kind1_btn_high ? (t.btn_raw != 8'd0) : (t.btn_raw == 8'd0);
            end
            d.start   = pressed;
            fail_cnt  = '0;
            held_bits = d;
        end else begin
            if (fail_cnt != FAIL_COUNT_MAX) fail_cnt = fail_cnt + 8'd1;
            if (fail_cnt >= pad_cfg.fail_limit) begin
                pad_port  = PORT_SEARCHING;
                pad_kind  = KIND_NONE;
                held_bits = '0;
                r.lost    = 1'b1;
            end
        end
        r.stick = held_bits;
        r.port  = pad_port;
        r.kind  = pad_kind;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("ERROR at %0t: %s got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_pad_result got;
        t_pad_result want;
        t_poll_tick  t;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.a     = out_ch.a_pressed;
                got.b     = out_ch.b_pressed;
                got.stick = '{right: out_ch.right_pressed, left: out_ch.left_pressed,
                              down: out_ch.down_pressed, up: out_ch.up_pressed,
                              start: out_ch.start_pressed};
                got.port  = out_ch.joystick_port;
                got.kind  = out_ch.joystick_kind;
                got.lost  = out_ch.joystick_lost;
                if (pad_result_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = pad_result_q.pop_front();
                    if (got.a != want.a) report_mismatch("a_pressed", got.a, want.a);
                    if (got.b != want.b) report_mismatch("b_pressed", got.b, want.b);
                    if (got.stick.start != want.stick.start)
                        report_mismatch("start_pressed", got.stick.start, want.stick.start);
                    if (got.stick.up != want.stick.up)
                        report_mismatch("up_pressed", got.stick.up, want.stick.up);
                    if (got.stick.down != want.stick.down)
                        report_mismatch("down_pressed", got.stick.down, want.stick.down);
                    if (got.stick.left != want.stick.left)
                        report_mismatch("left_pressed", got.stick.left, want.stick.left);
                    if (got.stick.right != want.stick.right)
                        report_mismatch("right_pressed", got.stick.right, want.stick.right);
                    if (got.port != want.port)
                        report_mismatch("joystick_port", got.port, want.port);
                    if (got.kind != want.kind)
                        report_mismatch("joystick_kind", got.kind, want.kind);
                    if (got.lost != want.lost)
                        report_mismatch("joystick_lost", got.lost, want.lost);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                t.pin1    = in_ch.pin1_levels;
                t.pin2    = in_ch.pin2_levels;
                t.now_ms  = in_ch.now_ms;
                t.kinds   = in_ch.port_probe_kinds;
                t.read_ok = in_ch.read_ok;
                t.x_raw   = in_ch.stick_x_raw;
                t.y_raw   = in_ch.stick_y_raw;
                t.btn_raw = in_ch.stick_button_raw;
                pad_result_q.push_back(predict_tick(t));
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= !idle_on || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_poll_tick poll(input logic [2:0] p1, input logic [2:0] p2,
                                        input logic [31:0] now, input logic [5:0] kinds,
                                        input logic ok, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] btn);
        t_poll_tick t;
        t = '{pin1: p1, pin2: p2, now_ms: now, kinds: kinds, read_ok: ok,
              x_raw: x, y_raw: y, btn_raw: btn};
        return t;
    endfunction

    task automatic send_tick(input t_poll_tick t);
        while (idle_on && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.pin1_levels      <= t.pin1;
        in_ch.pin2_levels      <= t.pin2;
        in_ch.now_ms           <= t.now_ms;
        in_ch.port_probe_kinds <= t.kinds;
        in_ch.read_ok          <= t.read_ok;
        in_ch.stick_x_raw      <= t.x_raw;
        in_ch.stick_y_raw      <= t.y_raw;
        in_ch.stick_button_raw <= t.btn_raw;
        tick_ms = t.now_ms;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pad_result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input t_pad_cfg c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DEAD_ZONE;
        cfg_data <= CFG_DATA_W'(c.dead_zone);
        @(posedge i_clk);
        cfg_idx  <= CFG_INVERT_X;
        cfg_data <= CFG_DATA_W'(c.invert_x);
        @(posedge i_clk);
        cfg_idx  <= CFG_INVERT_Y;
        cfg_data <= CFG_DATA_W'(c.invert_y);
        @(posedge i_clk);
        cfg_idx  <= CFG_REPROBE_MS;
        cfg_data <= c.reprobe_ms;
        @(posedge i_clk);
        cfg_idx  <= CFG_FAIL_LIMIT;
        cfg_data <= CFG_DATA_W'(c.fail_limit);
        @(posedge i_clk);
        cfg_idx  <= CFG_KIND1_BTN_HIGH;
        cfg_data <= CFG_DATA_W'(c.kind1_btn_high);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        pad_cfg = c;
    endtask

    task automatic test_button_scan();
        send_tick(poll(3'b111, 3'b111, 32'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b000, 3'b000, 32'd1, 6'd0, 1'b1, 8'hff, 8'hff, 8'hff));
        send_tick(poll(3'b101, 3'b010, 32'd2, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_probe_and_bind();
        // port 0 answers with the unused kind code, port 1 with the second kind
        send_tick(poll(3'b111, 3'b111, 32'd1000, 6'b11_10_11, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'd1999, 6'b11_10_11, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b101, 3'b111, 32'd2000, 6'b11_10_11, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b101, 3'b111, 32'd2001, 6'd0, 1'b1, 8'd0, 8'd0, 8'd1));
    endtask

    task automatic test_second_kind_read();
        send_tick(poll(3'b111, 3'b111, 32'd2002, 6'd0, 1'b1, 8'h80, 8'h7f, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'd2003, 6'd0, 1'b1, 8'h21, 8'hdf, 8'd1));
        send_tick(poll(3'b111, 3'b111, 32'd2004, 6'd0, 1'b1, 8'h20, 8'he0, 8'd5));
    endtask

    task automatic test_read_failures();
        send_tick(poll(3'b010, 3'b101, 32'd2005, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b010, 3'b101, 32'd2006, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b010, 3'b101, 32'd2007, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        // searching now: read fields have no effect
        send_tick(poll(3'b010, 3'b101, 32'd2008, 6'd0, 1'b1, 8'hff, 8'h00, 8'd0));
    endtask

    task automatic test_first_kind_read();
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff00, 6'b01_00_00, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff01, 6'd0, 1'b1, 8'd0, 8'd255, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff02, 6'd0, 1'b1, 8'd255, 8'd0, 8'd255));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff03, 6'd0, 1'b1, 8'd128, 8'd128, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff04, 6'd0, 1'b1, 8'd160, 8'd96, 8'd1));
        drain_results();
        write_config('{dead_zone: 7'd0, invert_x: 1'b1, invert_y: 1'b1, reprobe_ms: 16'd0,
                       fail_limit: 8'd1, kind1_btn_high: 1'b1});
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff05, 6'd0, 1'b1, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff06, 6'd0, 1'b1, 8'd129, 8'd127, 8'd1));
        drain_results();
        write_config('{dead_zone: 7'd127, invert_x: 1'b1, invert_y: 1'b1,
                       reprobe_ms: 16'd65535, fail_limit: 8'd255, kind1_btn_high: 1'b1});
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff07, 6'd0, 1'b1, 8'd0, 8'd255, 8'd7));
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff08, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        drain_results();
        write_config('{dead_zone: 7'd127, invert_x: 1'b0, invert_y: 1'b0,
                       reprobe_ms: 16'd65535, fail_limit: 8'd1, kind1_btn_high: 1'b0});
        send_tick(poll(3'b111, 3'b111, 32'hffff_ff09, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_probe_timing();
        // time difference wraps across zero
        send_tick(poll(3'b111, 3'b111, 32'h0000_fe00, 6'b01_01_01, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'h0000_feff, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        drain_results();
        write_config('{dead_zone: 7'd32, invert_x: 1'b0, invert_y: 1'b0, reprobe_ms: 16'd0,
                       fail_limit: 8'd3, kind1_btn_high: 1'b0});
        send_tick(poll(3'b111, 3'b111, 32'h0000_feff, 6'b10_11_00, 1'b0, 8'd0, 8'd0, 8'd0));
        send_tick(poll(3'b111, 3'b111, 32'h0000_feff, 6'b10_11_00, 1'b0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_random_traffic();
        t_pad_cfg   c;
        t_poll_tick t;
        logic [7:0] stick_edges[4];
        int         ph;
        int         n;
        int         step;
        stick_edges = '{8'd0, 8'd127, 8'd128, 8'd255};
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            if (ph == 0) begin
                c = '{dead_zone: 7'd0, invert_x: 1'b0, invert_y: 1'b1, reprobe_ms: 16'd0,
                      fail_limit: 8'd1, kind1_btn_high: 1'b0};
            end else if (ph == 1) begin
                c = '{dead_zone: 7'd127, invert_x: 1'b1, invert_y: 1'b0,
                      reprobe_ms: 16'd65535, fail_limit: 8'd255, kind1_btn_high: 1'b1};
            end else begin
                c.dead_zone      = 7'($urandom_range(127, 0));
                c.invert_x       = 1'($urandom_range(1, 0));
                c.invert_y       = 1'($urandom_range(1, 0));
                c.reprobe_ms     = ($urandom_range(99) < 50) ? 16'($urandom_range(50, 0))
                                                             : 16'($urandom_range(65535, 0));
                c.fail_limit     = 8'($urandom_range(12, 1));
                c.kind1_btn_high = 1'($urandom_range(1, 0));
            end
            write_config(c);
            idle_on    = (ph != 2);
            burst_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (pad_port == PORT_SEARCHING && $urandom_range(99) < 60)
                    step = int'(pad_cfg.reprobe_ms) + $urandom_range(3, 0);
                else
                    step = $urandom_range(40, 0);
                if ($urandom_range(99) < 2) t.now_ms = $urandom();
                else t.now_ms = tick_ms + step;
                t.pin1  = 3'($urandom_range(7, 0));
                t.pin2  = 3'($urandom_range(7, 0));
                t.kinds = 6'($urandom_range(63, 0));
                if (pad_port != PORT_SEARCHING && burst_left == 0 && $urandom_range(99) < 4)
                    burst_left = $urandom_range(int'(pad_cfg.fail_limit) + 1, 1);
                if (burst_left > 0) begin
                    t.read_ok = 1'b0;
                    burst_left--;
                end else begin
                    t.read_ok = ($urandom_range(99) >= 5);
                end
                t.x_raw   = ($urandom_range(99) < 15) ? stick_edges[2'($urandom_range(3, 0))]
                                                      : 8'($urandom_range(255, 0));
                t.y_raw   = ($urandom_range(99) < 15) ? stick_edges[2'($urandom_range(3, 0))]
                                                      : 8'($urandom_range(255, 0));
                t.btn_raw = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255, 0));
                send_tick(t);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_data               = '0;
        in_ch.valid            = 1'b0;
        in_ch.pin1_levels      = '0;
        in_ch.pin2_levels      = '0;
        in_ch.now_ms           = '0;
        in_ch.port_probe_kinds = '0;
        in_ch.read_ok          = 1'b0;
        in_ch.stick_x_raw      = '0;
        in_ch.stick_y_raw      = '0;
        in_ch.stick_button_raw = '0;
        idle_on                = 1'b1;
        tick_ms                = '0;
        burst_left             = 0;
        pad_cfg = '{dead_zone: DEAD_ZONE_RST, invert_x: 1'b0, invert_y: 1'b0,
                    reprobe_ms: REPROBE_RST, fail_limit: FAIL_LIMIT_RST, kind1_btn_high: 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_button_scan();
        test_probe_and_bind();
        test_second_kind_read();
        test_read_failures();
        test_first_kind_read();
        test_probe_timing();
        test_random_traffic();
        drain_results();

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/jpsm_pkg.sv
hdl/jpsm_in_if.sv
hdl/jpsm_out_if.sv
hdl/joystick_port_scan_pad_mapper.sv
tb/testbench.sv
